>>> rtl/kpf_pkg.sv
// Shared types and constants for the keyed pool with oldest-first replacement.
package kpf_pkg;

    // Default pool depth and the fixed field widths.
    localparam int unsigned ENTRIES_DEF = 16;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned SLOT_W      = 4;

    // Largest stamp; a full pool only replaces slots stamped below it.
    localparam logic [WORD_W-1:0] STAMP_MAX = 32'hFFFF_FFFF;

    // Operation code of an input word.
    typedef enum logic {
        FUNC_DEPOSIT  = 1'b0,
        FUNC_WITHDRAW = 1'b1
    } t_func;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // One stored pool entry.
    typedef struct packed {
        logic [WORD_W-1:0] stamp;
        logic [WORD_W-1:0] handle;
        logic [WORD_W-1:0] format;
        logic [WORD_W-1:0] size;
        logic [WORD_W-1:0] aux;
    } t_entry;

    // One input word.
    typedef struct packed {
        t_func             func;
        logic [WORD_W-1:0] handle;
        logic [WORD_W-1:0] format_key;
        logic [WORD_W-1:0] size_key;
        logic [WORD_W-1:0] aux_word;
    } t_item;

    // One result word.
    typedef struct packed {
        logic              done_res;
        logic              evicted;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] out_handle;
        logic [WORD_W-1:0] out_format;
        logic [WORD_W-1:0] out_size;
        logic [WORD_W-1:0] out_aux;
    } t_result;

endpackage

>>> rtl/kpf_store.sv
// Entry memory: one write port and one read port with a registered read.
module kpf_store #(
    parameter int unsigned ENTRIES = kpf_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(ENTRIES)-1:0] i_waddr,
    input  kpf_pkg::t_entry            i_wdata,
    input  logic [$clog2(ENTRIES)-1:0] i_raddr,
    output kpf_pkg::t_entry            o_rdata
);

    kpf_pkg::t_entry r_mem [ENTRIES];
    kpf_pkg::t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/kpf_ctrl.sv
// Scan and write-back controller: walks the entry memory, picks a slot, updates it.
module kpf_ctrl #(
    parameter int unsigned ENTRIES = kpf_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  kpf_pkg::t_item             i_item,
    output logic                       o_busy,
    input  logic                       i_res_ready,
    output logic                       o_res_vld,
    output kpf_pkg::t_result           o_res,
    output logic [$clog2(ENTRIES)-1:0] o_mem_raddr,
    input  kpf_pkg::t_entry            i_mem_rdata,
    output logic                       o_mem_we,
    output logic [$clog2(ENTRIES)-1:0] o_mem_waddr,
    output kpf_pkg::t_entry            o_mem_wdata
);

    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam int unsigned SW = kpf_pkg::SLOT_W;
    localparam int unsigned WW = kpf_pkg::WORD_W;

    kpf_pkg::t_state  r_state,  n_state;
    kpf_pkg::t_item   r_item,   n_item;
    logic [CW-1:0]    r_idx,    n_idx;
    logic             r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]    r_cmp_idx, n_cmp_idx;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [WW-1:0]    r_counter, n_counter;
    logic             r_free_found, n_free_found;
    logic [IW-1:0]    r_free_idx,   n_free_idx;
    logic             r_found,      n_found;
    logic [WW-1:0]    r_best,       n_best;
    logic [IW-1:0]    r_best_idx,   n_best_idx;
    logic [WW-1:0]    r_best_handle, n_best_handle;

    logic          slot_v;
    logic          dep_older;
    logic          wdr_match;
    logic [IW-1:0] dep_tgt;
    logic          dep_write;
    logic [WW-1:0] next_stamp;

    // Compare terms for the entry whose read data is arriving.
    assign slot_v     = r_valid[r_cmp_idx];
    assign dep_older  = i_mem_rdata.stamp < r_best;
    assign wdr_match  = slot_v
                        && (i_mem_rdata.format == r_item.format_key)
                        && (i_mem_rdata.size == r_item.size_key)
                        && (i_mem_rdata.stamp <= r_best);
    assign dep_tgt    = r_free_found ? r_free_idx : r_best_idx;
    assign dep_write  = r_free_found || r_found;
    assign next_stamp = r_counter + WW'(1);
    assign o_busy     = (r_state != kpf_pkg::ST_IDLE);

    // Next state, scan bookkeeping and write-back.
    always_comb begin
        n_state       = r_state;
        n_item        = r_item;
        n_idx         = r_idx;
        n_cmp_vld     = 1'b0;
        n_cmp_idx     = r_cmp_idx;
        n_valid       = r_valid;
        n_counter     = r_counter;
        n_free_found  = r_free_found;
        n_free_idx    = r_free_idx;
        n_found       = r_found;
        n_best        = r_best;
        n_best_idx    = r_best_idx;
        n_best_handle = r_best_handle;
        o_mem_raddr   = r_idx[IW-1:0];
        o_mem_we      = 1'b0;
        o_mem_waddr   = '0;
        o_mem_wdata   = '0;
        o_res_vld     = 1'b0;
        o_res         = '0;

        unique case (r_state)
            kpf_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_item       = i_item;
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    n_found      = 1'b0;
                    n_best       = kpf_pkg::STAMP_MAX;
                    n_state      = kpf_pkg::ST_SCAN;
                end
            end

            kpf_pkg::ST_SCAN: begin
                // Issue one read a cycle until every slot has been addressed.
                if (r_idx < CW'(ENTRIES)) begin
                    n_idx     = r_idx + CW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[IW-1:0];
                end else begin
                    n_state = kpf_pkg::ST_FINISH;
                end

                // Judge the slot read in the previous cycle.
                if (r_cmp_vld) begin
                    if (r_item.func == kpf_pkg::FUNC_DEPOSIT) begin
                        if (!slot_v) begin
                            if (!r_free_found) begin
                                n_free_found = 1'b1;
                                n_free_idx   = r_cmp_idx;
                            end
                        end else if (dep_older) begin
                            n_found       = 1'b1;
                            n_best        = i_mem_rdata.stamp;
                            n_best_idx    = r_cmp_idx;
                            n_best_handle = i_mem_rdata.handle;
                        end
                    end else if (wdr_match) begin
                        n_found       = 1'b1;
                        n_best        = i_mem_rdata.stamp;
                        n_best_idx    = r_cmp_idx;
                        n_best_handle = i_mem_rdata.handle;
                    end
                end
            end

            kpf_pkg::ST_FINISH: begin
                if (i_res_ready) begin
                    n_state   = kpf_pkg::ST_IDLE;
                    o_res_vld = 1'b1;
                    if (r_item.func == kpf_pkg::FUNC_DEPOSIT) begin
                        // A refused deposit leaves everything alone and reports zeros.
                        if (dep_write) begin
                            o_mem_we           = 1'b1;
                            o_mem_waddr        = dep_tgt;
                            o_mem_wdata.stamp  = next_stamp;
                            o_mem_wdata.handle = r_item.handle;
                            o_mem_wdata.format = r_item.format_key;
                            o_mem_wdata.size   = r_item.size_key;
                            o_mem_wdata.aux    = r_item.aux_word;
                            n_valid[dep_tgt]   = 1'b1;
                            n_counter          = next_stamp;
                            o_res.done_res     = 1'b1;
                            o_res.slot         = SW'(dep_tgt);
                            if (!r_free_found) begin
                                o_res.evicted    = 1'b1;
                                o_res.out_handle = r_best_handle;
                            end
                        end
                    end else if (r_found) begin
                        // Free the slot and clear its auxiliary word.
                        o_mem_we            = 1'b1;
                        o_mem_waddr         = r_best_idx;
                        o_mem_wdata.stamp   = r_best;
                        o_mem_wdata.handle  = r_best_handle;
                        o_mem_wdata.format  = r_item.format_key;
                        o_mem_wdata.size    = r_item.size_key;
                        o_mem_wdata.aux     = '0;
                        n_valid[r_best_idx] = 1'b0;
                        o_res.done_res      = 1'b1;
                        o_res.slot          = SW'(r_best_idx);
                        o_res.out_handle    = r_best_handle;
                        o_res.out_format    = r_item.format_key;
                        o_res.out_size      = r_item.size_key;
                        o_res.out_aux       = '0;
                    end
                end
            end

            default: begin
                n_state = kpf_pkg::ST_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kpf_pkg::ST_IDLE;
            r_cmp_vld <= 1'b0;
            r_valid   <= '0;
            r_counter <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_valid   <= n_valid;
            r_counter <= n_counter;
        end
    end

    // Scan payload registers.
    always_ff @(posedge i_clk) begin
        r_item        <= n_item;
        r_idx         <= n_idx;
        r_cmp_idx     <= n_cmp_idx;
        r_free_found  <= n_free_found;
        r_free_idx    <= n_free_idx;
        r_found       <= n_found;
        r_best        <= n_best;
        r_best_idx    <= n_best_idx;
        r_best_handle <= n_best_handle;
    end

endmodule

>>> rtl/keyed_pool_fifo_replace_unit.sv
// Top level of the keyed pool: input capture, entry memory, controller and result register.
//
//  Channel | Direction | Handshake               | Word
//  --------+-----------+-------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_stall | func, handle, format/size keys, aux word
//  out     | output    | o_out_valid / i_out_stall | done, evicted, slot, handle, keys, aux
//
//  A new word is taken only while the controller is idle, after the previous word's
//  write-back; the scan reads one slot a cycle from the single-read-port entry memory.
//  Reset clears the valid bits, the stamp counter and all handshake state; the memory
//  itself is not cleared, since the valid bits guard every read.
//  A stalled result holds in the output register; the next word is still taken and
//  scanned, and waits at write-back until the output register is free.
module keyed_pool_fifo_replace_unit #(
    parameter int unsigned ENTRIES = kpf_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [31:0] i_handle,
    input  logic [31:0] i_format_key,
    input  logic [31:0] i_size_key,
    input  logic [31:0] i_aux_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_done_res,
    output logic        o_evicted,
    output logic [3:0]  o_slot,
    output logic [31:0] o_out_handle,
    output logic [31:0] o_out_format,
    output logic [31:0] o_out_size,
    output logic [31:0] o_out_aux
);

    localparam int unsigned IW = $clog2(ENTRIES);

    kpf_pkg::t_item   in_item;
    logic             in_acc;
    logic             ctrl_busy;
    logic             out_free;
    logic             res_vld;
    kpf_pkg::t_result res;
    logic [IW-1:0]    mem_raddr;
    logic [IW-1:0]    mem_waddr;
    logic             mem_we;
    kpf_pkg::t_entry  mem_rdata;
    kpf_pkg::t_entry  mem_wdata;
    logic             r_out_vld, n_out_vld;
    kpf_pkg::t_result r_res;

    // Input word assembly and acceptance.
    assign in_item.func       = kpf_pkg::t_func'(i_func);
    assign in_item.handle     = i_handle;
    assign in_item.format_key = i_format_key;
    assign in_item.size_key   = i_size_key;
    assign in_item.aux_word   = i_aux_word;
    assign o_in_stall         = ctrl_busy;
    assign in_acc             = i_in_valid && !o_in_stall;
    assign out_free           = !r_out_vld || !i_out_stall;

    kpf_store #(
        .ENTRIES(ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    kpf_ctrl #(
        .ENTRIES(ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_acc),
        .i_item      (in_item),
        .o_busy      (ctrl_busy),
        .i_res_ready (out_free),
        .o_res_vld   (res_vld),
        .o_res       (res),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata)
    );

    // Output register: loaded on a finished word, held while stalled.
    assign n_out_vld = res_vld || (r_out_vld && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld) begin
            r_res <= res;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_done_res   = r_res.done_res;
    assign o_evicted    = r_res.evicted;
    assign o_slot       = r_res.slot;
    assign o_out_handle = r_res.out_handle;
    assign o_out_format = r_res.out_format;
    assign o_out_size   = r_res.out_size;
    assign o_out_aux    = r_res.out_aux;

    // The controller only finishes a word into a free output register.
    a_res_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_vld |-> out_free)
        else $error("result produced while output register is held");

    // An accepted word keeps the input side stalled in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input not stalled after accepting a word");

    // An eviction is always a completed deposit.
    a_evict_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted |-> o_done_res)
        else $error("eviction reported without completion");

    // A memory write happens only when a result is produced.
    a_write_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> res_vld)
        else $error("entry memory written outside write-back");

endmodule

>>> tb/keyed_pool_fifo_replace_unit_tb.sv
// Self-checking testbench for the keyed buffer pool with oldest-first replacement.
`timescale 1ns / 1ps

module keyed_pool_fifo_replace_unit_tb;

    localparam int unsigned NSLOT       = kpf_pkg::ENTRIES_DEF;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned DRAIN_WAIT  = 40;

    // Clock, reset and the ports of the block.
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        i_func       = 1'b0;
    logic [31:0] i_handle     = '0;
    logic [31:0] i_format_key = '0;
    logic [31:0] i_size_key   = '0;
    logic [31:0] i_aux_word   = '0;
    logic        i_out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_done_res;
    logic        o_evicted;
    logic [3:0]  o_slot;
    logic [31:0] o_out_handle;
    logic [31:0] o_out_format;
    logic [31:0] o_out_size;
    logic [31:0] o_out_aux;

    // Shadow copy of the pool used to predict each result word.
    logic        pool_valid  [NSLOT];
    logic [31:0] pool_stamp  [NSLOT];
    logic [31:0] pool_handle [NSLOT];
    logic [31:0] pool_format [NSLOT];
    logic [31:0] pool_size   [NSLOT];
    logic [31:0] stamp_count = '0;

    // Expected result words, oldest first.
    kpf_pkg::t_result pending_results[$];

    // Key sets that make withdraws hit often.
    logic [31:0] fmt_keys  [4];
    logic [31:0] size_keys [3];

    // Run control and statistics.
    logic        tx_idle_on    = 1'b0;
    logic        rx_idle_on    = 1'b0;
    int unsigned hold_requests = 0;
    int unsigned fail_cnt      = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned n_deposit     = 0;
    int unsigned n_evict       = 0;
    int unsigned n_hit         = 0;
    int unsigned n_miss        = 0;

    keyed_pool_fifo_replace_unit u_top (.*);

    always #5 i_clk = ~i_clk;

    // Work out the result of one accepted word and update the shadow pool.
    task automatic predict_pool_word(input kpf_pkg::t_item w, output kpf_pkg::t_result r);
        int          pick;
        logic [31:0] best;
        r    = '0;
        pick = -1;
        if (w.func == kpf_pkg::FUNC_DEPOSIT) begin
            n_deposit++;
            // Lowest free slot first.
            for (int k = 0; k < NSLOT; k++) begin
                if (!pool_valid[k] && pick < 0) begin
                    pick = k;
                end
            end
            if (pick >= 0) begin
                r.done_res = 1'b1;
                r.slot     = 4'(pick);
            end else begin
                // Full pool: first slot with the smallest stamp below the maximum.
                best = kpf_pkg::STAMP_MAX;
                for (int k = 0; k < NSLOT; k++) begin
                    if (pool_stamp[k] < best) begin
                        best = pool_stamp[k];
                        pick = k;
                    end
                end
                if (pick >= 0) begin
                    n_evict++;
                    r.done_res   = 1'b1;
                    r.evicted    = 1'b1;
                    r.slot       = 4'(pick);
                    r.out_handle = pool_handle[pick];
                end
            end
            if (pick >= 0) begin
                stamp_count       = stamp_count + 1;
                pool_valid[pick]  = 1'b1;
                pool_stamp[pick]  = stamp_count;
                pool_handle[pick] = w.handle;
                pool_format[pick] = w.format_key;
                pool_size[pick]   = w.size_key;
            end
        end else begin
            // Oldest matching entry; on a stamp tie the highest slot wins.
            best = kpf_pkg::STAMP_MAX;
            for (int k = 0; k < NSLOT; k++) begin
                if (pool_valid[k] && pool_format[k] == w.format_key &&
                    pool_size[k] == w.size_key && pool_stamp[k] <= best) begin
                    best = pool_stamp[k];
                    pick = k;
                end
            end
            if (pick >= 0) begin
                n_hit++;
                pool_valid[pick] = 1'b0;
                r.done_res       = 1'b1;
                r.slot           = 4'(pick);
                r.out_handle     = pool_handle[pick];
                r.out_format     = pool_format[pick];
                r.out_size       = pool_size[pick];
            end else begin
                n_miss++;
            end
        end
    endtask

    // Offer one word, wait for it to be taken, and record its expected result.
    task automatic send_word(input kpf_pkg::t_item w);
        kpf_pkg::t_result r;
        if (tx_idle_on && $urandom_range(3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(16, 1)) @(negedge i_clk);
        end
        i_func       = w.func;
        i_handle     = w.handle;
        i_format_key = w.format_key;
        i_size_key   = w.size_key;
        i_aux_word   = w.aux_word;
        i_in_valid   = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_pool_word(w, r);
        pending_results.push_back(r);
        @(negedge i_clk);
    endtask

    // Random word; most keys come from small sets so that withdraws find matches.
    function automatic kpf_pkg::t_item rand_word(int unsigned dep_pct);
        kpf_pkg::t_item w;
        w.func       = ($urandom_range(99) < dep_pct) ? kpf_pkg::FUNC_DEPOSIT
                                                      : kpf_pkg::FUNC_WITHDRAW;
        w.handle     = $urandom();
        w.aux_word   = $urandom();
        if ($urandom_range(9) == 0) begin
            w.format_key = $urandom();
            w.size_key   = $urandom();
        end else begin
            w.format_key = fmt_keys[$urandom_range(3)];
            w.size_key   = size_keys[$urandom_range(2)];
        end
        return w;
    endfunction

    // Empty-pool miss, fill, eviction of the oldest, oldest-match withdraws, reuse.
    task automatic test_directed();
        kpf_pkg::t_item w;
        w      = '0;
        w.func = kpf_pkg::FUNC_WITHDRAW;
        send_word(w);
        for (int n = 0; n < NSLOT; n++) begin
            w.func       = kpf_pkg::FUNC_DEPOSIT;
            w.handle     = n[0] ? ~32'(n) : 32'(n);
            w.format_key = (n % 3 == 0) ? 32'h0 : 32'hFFFF_FFFF;
            w.size_key   = n[0] ? 32'hFFFF_FFFF : 32'h0;
            w.aux_word   = ~w.handle;
            send_word(w);
        end
        // The pool is full, so these two replace slots zero and one.
        for (int n = 0; n < 2; n++) begin
            w.func       = kpf_pkg::FUNC_DEPOSIT;
            w.handle     = 32'hA5A5_0000 + 32'(n);
            w.format_key = 32'hFFFF_FFFF;
            w.size_key   = 32'hFFFF_FFFF;
            w.aux_word   = 32'hFFFF_FFFF;
            send_word(w);
        end
        // The first three key pairs each have several entries and the oldest must come back; the last pair has none.
        w.func       = kpf_pkg::FUNC_WITHDRAW;
        w.format_key = 32'hFFFF_FFFF;
        w.size_key   = 32'hFFFF_FFFF;
        send_word(w);
        w.format_key = 32'h0;
        w.size_key   = 32'h0;
        send_word(w);
        w.size_key   = 32'hFFFF_FFFF;
        send_word(w);
        w.format_key = 32'h1234_5678;
        w.size_key   = 32'h9ABC_DEF0;
        send_word(w);
        // A deposit now lands in the lowest freed slot.
        w.func       = kpf_pkg::FUNC_DEPOSIT;
        w.handle     = 32'h5A5A_5A5A;
        send_word(w);
    endtask

    // Phases of mixed traffic with varying deposit share, so the pool fills and drains.
    task automatic test_random_traffic();
        int unsigned dep_pct;
        fmt_keys[0]  = 32'h0;
        fmt_keys[1]  = 32'hFFFF_FFFF;
        fmt_keys[2]  = $urandom();
        fmt_keys[3]  = $urandom();
        size_keys[0] = 32'h0;
        size_keys[1] = 32'hFFFF_FFFF;
        size_keys[2] = $urandom();
        for (int phase = 0; phase < 16; phase++) begin
            case ($urandom_range(3))
                0:       dep_pct = 25;
                1:       dep_pct = 50;
                2:       dep_pct = 75;
                default: dep_pct = 90;
            endcase
            repeat (50) send_word(rand_word(dep_pct));
        end
    endtask

    // The receiver holds off for a long time while words keep coming.
    task automatic test_output_hold();
        tx_idle_on = 1'b0;
        hold_requests++;
        repeat (8) send_word(rand_word(60));
    endtask

    // Back-to-back words with both sides always ready.
    task automatic test_steady_stream();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (120) send_word(rand_word(55));
    endtask

    // Receiver: long holds on request, otherwise random stall and ready bursts.
    initial begin : rx_side
        int unsigned holds_served;
        int unsigned hold_left;
        int unsigned run_left;
        logic        run_stall;
        logic        nxt_stall;
        holds_served = 0;
        hold_left    = 0;
        run_left     = 0;
        run_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                nxt_stall = 1'b1;
            end else if (!rx_idle_on) begin
                nxt_stall = 1'b0;
            end else begin
                if (run_left == 0) begin
                    run_stall = ($urandom_range(2) == 0);
                    run_left  = $urandom_range(16, 1);
                end
                run_left--;
                nxt_stall = run_stall;
            end
            i_out_stall = nxt_stall;
        end
    end

    // Compare one field of a result word.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_cnt++;
        end
    endtask

    // Check every accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        kpf_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation pending");
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                check_field("done_res", 32'(want.done_res), 32'(o_done_res));
                check_field("evicted", 32'(want.evicted), 32'(o_evicted));
                check_field("slot", 32'(want.slot), 32'(o_slot));
                check_field("out_handle", want.out_handle, o_out_handle);
                check_field("out_format", want.out_format, o_out_format);
                check_field("out_size", want.out_size, o_out_size);
                check_field("out_aux", want.out_aux, o_out_aux);
            end
        end
    end

    // Watchdog: too long without any word moving on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Main sequence.
    initial begin
        for (int k = 0; k < NSLOT; k++) begin
            pool_valid[k]  = 1'b0;
            pool_stamp[k]  = '0;
            pool_handle[k] = '0;
            pool_format[k] = '0;
            pool_size[k]   = '0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n    = 1'b1;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_directed();
        test_random_traffic();
        test_output_hold();
        test_steady_stream();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Sent %0d deposits (%0d evicting) and %0d withdraws (%0d hits, %0d misses),",
                 n_deposit, n_evict, n_hit + n_miss, n_hit, n_miss);
        $display("with random stalls on both sides, one long output hold and a steady stream.");
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
